// ===== rtl/pctl_pkg.sv =====
// Shared constants and types for the percentile interpolator.
`timescale 1ns / 1ps
package pctl_pkg;

  localparam int MAX_SAMPLES  = 1024;
  localparam int IDX_W        = $clog2(MAX_SAMPLES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int SAMPLE_W     = 32;
  localparam int PCT_W        = 15;
  localparam int VALUE_W      = 40;

  localparam logic [PCT_W-1:0] PCT_FULL_Q8  = PCT_W'(25600);
  localparam logic [PCT_W-1:0] PCT_RESET_Q8 = PCT_W'(12800);
  localparam logic [CNT_W-1:0] CNT_MAX      = CNT_W'(MAX_SAMPLES);

  // Divide by 100 as a multiply by ceil(2^31 / 100) and a shift; exact below 2^25.
  localparam int          RANK_PROD_W = 50;
  localparam int          RECIP_SHIFT = 31;
  localparam logic [24:0] RECIP_100   = 25'(21474837);

  typedef logic [IDX_W-1:0] idx_t;

  // Store port controls from the sequencer.
  typedef struct packed {
    logic we;
    idx_t waddr;
    idx_t raddr;
  } store_req_t;

endpackage

// ===== rtl/percentile_interpolator.sv =====
// Top level: sample loader, rank sequencer and interpolation of one percentile.
`timescale 1ns / 1ps
// Load: one sample word per cycle while s_axis_tready is high (stored in arrival order).
// After the word marked tlast: product, rank scaling by 1/100, then a rank sweep over
// the sample store's single read port, then multiply and add; input stays stalled until
// the result word is taken.
// Synchronous active-high rst clears the sequencer, the count and the drop flag and
// sets percent_q8 to 50 percent; the sample store itself is not cleared.
module percentile_interpolator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [pctl_pkg::PCT_W-1:0] cfg_wdata,      // percent_q8
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,   // [31:0] sample
  input  logic                       s_axis_tlast,   // is_last
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [55:0]                m_axis_tdata    // [39:0] value_q8, [50:40] sample_count,
                                                     // [51] overflowed, [55:52] zero
);
  import pctl_pkg::*;

  typedef enum logic [8:0] {
    ST_LOAD   = 9'b000000001,
    ST_PREP   = 9'b000000010,
    ST_DIV    = 9'b000000100,
    ST_SCAN_I = 9'b000001000,
    ST_SCAN_A = 9'b000010000,
    ST_SCAN_J = 9'b000100000,
    ST_MUL    = 9'b001000000,
    ST_ADD    = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  state_t             state;
  logic [PCT_W-1:0]   percent_q8;
  logic [CNT_W-1:0]   count;
  logic               drop;

  // Rank scaling: multiply by the reciprocal of 100, keep the high bits.
  logic [24:0]        div_q;
  logic [RANK_PROD_W-1:0] rank_prod;

  // Rank sweep.
  logic [CNT_W-1:0]   scan_i;
  logic [CNT_W-1:0]   scan_j;
  logic [IDX_W-1:0]   pend_idx;
  logic               pend;
  logic [CNT_W-1:0]   rank;
  logic signed [SAMPLE_W-1:0] cur;
  logic signed [SAMPLE_W-1:0] lower;
  logic signed [SAMPLE_W-1:0] upper;
  logic               is_less;

  logic signed [41:0] prod;
  logic [VALUE_W-1:0] value_q8;

  store_req_t            sreq;
  logic [SAMPLE_W-1:0]   rdata;
  logic signed [SAMPLE_W-1:0] rd_s;
  logic [PCT_W-1:0]      pct_sat;
  logic [IDX_W-1:0]      lo;
  logic [7:0]            frac;
  logic [CNT_W-1:0]      lo_up;
  logic signed [32:0]    diff;

  assign s_axis_tready = (state == ST_LOAD);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {4'b0, drop, count, value_q8};

  assign pct_sat = (percent_q8 > PCT_FULL_Q8) ? PCT_FULL_Q8 : percent_q8;
  assign lo      = div_q[IDX_W+7:8];
  assign frac    = div_q[7:0];
  assign lo_up   = {1'b0, lo} + CNT_W'(1);

  assign rank_prod = RANK_PROD_W'(div_q) * RANK_PROD_W'(RECIP_100);

  assign rd_s    = signed'(rdata);
  // Ties break by store address so every sample gets a distinct rank.
  assign is_less = (rd_s < cur) || ((rd_s == cur) && ({1'b0, pend_idx} < scan_i));

  assign diff    = (frac == 8'd0) ? 33'sd0 : (33'(upper) - 33'(lower));

  // Store port: write while loading and there is room, read the outer then inner sweep address.
  always_comb begin
    sreq.we    = s_axis_tvalid && s_axis_tready && (count < CNT_MAX);
    sreq.waddr = count[IDX_W-1:0];
    case (state)
      ST_SCAN_I: sreq.raddr = scan_i[IDX_W-1:0];
      ST_SCAN_J: sreq.raddr = scan_j[IDX_W-1:0];
      default:   sreq.raddr = '0;
    endcase
  end

  pctl_store u_store (
    .clk   (clk),
    .req   (sreq),
    .wdata (s_axis_tdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_q8 <= PCT_RESET_Q8;
    end else if (cfg_we) begin
      percent_q8 <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      drop  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (s_axis_tvalid) begin
            // Keep while there is room, drop and flag otherwise.
            if (count < CNT_MAX) begin
              count <= count + CNT_W'(1);
            end else begin
              drop <= 1'b1;
            end
            if (s_axis_tlast) begin
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          div_q   <= 25'(pct_sat * (count - CNT_W'(1)));
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_q  <= 25'(rank_prod >> RECIP_SHIFT);
          scan_i <= '0;
          state  <= ST_SCAN_I;
        end
        ST_SCAN_I: begin
          state <= ST_SCAN_A;
        end
        ST_SCAN_A: begin
          // Hold the candidate, then sweep every sample against it.
          cur    <= rd_s;
          rank   <= '0;
          scan_j <= '0;
          state  <= ST_SCAN_J;
        end
        ST_SCAN_J: begin
          if (pend && is_less) begin
            rank <= rank + CNT_W'(1);
          end
          if (scan_j < count) begin
            pend     <= 1'b1;
            pend_idx <= scan_j[IDX_W-1:0];
            scan_j   <= scan_j + CNT_W'(1);
          end else begin
            pend <= 1'b0;
          end
          if (!pend && (scan_j == count)) begin
            if (rank == {1'b0, lo}) begin
              lower <= cur;
            end
            if (rank == lo_up) begin
              upper <= cur;
            end
            scan_i <= scan_i + CNT_W'(1);
            state  <= (scan_i + CNT_W'(1) == count) ? ST_MUL : ST_SCAN_I;
          end
        end
        ST_MUL: begin
          prod  <= 42'(diff * signed'({1'b0, frac}));
          state <= ST_ADD;
        end
        ST_ADD: begin
          value_q8 <= VALUE_W'(42'(lower) * 42'sd256 + prod);
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            count <= '0;
            drop  <= 1'b0;
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CNT_MAX)
    else $error("sample count above store size");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input open while result pending");
  a_set_clear: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |=> (count == '0 && !drop))
    else $error("set not cleared after result");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_I) |-> (scan_i < count))
    else $error("outer sweep index out of range");
`endif

endmodule

// ===== rtl/pctl_store.sv =====
// Sample store: one write port, one registered read port.
`timescale 1ns / 1ps
module pctl_store (
  input  logic                         clk,
  input  pctl_pkg::store_req_t         req,
  input  logic [pctl_pkg::SAMPLE_W-1:0] wdata,
  output logic [pctl_pkg::SAMPLE_W-1:0] rdata
);
  import pctl_pkg::*;

  logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
